>>> hdl/bpsd_pkg.sv
// Constants and types for the BMP pixel stream decoder.
// No dependencies. The top-level decoder imports this package.
`default_nettype none

package bpsd_pkg;

    // Largest width or height that is decoded.
    localparam int unsigned MAX_DIMENSION = 4096;

    // Width of a stored image dimension: it must hold MAX_DIMENSION itself.
    localparam int unsigned DIM_W = $clog2(MAX_DIMENSION + 1);
    // Width of a column or row counter: it holds up to MAX_DIMENSION - 1.
    localparam int unsigned CNT_W = $clog2(MAX_DIMENSION);

    // Fixed field widths at the ports.
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned COORD_W = 12;
    localparam int unsigned CHAN_W  = 8;

    // Header layout, as byte positions in the file.
    localparam int unsigned HEADER_BYTES = 54;
    localparam logic [5:0]  POS_OFFSET   = 6'd10;
    localparam logic [5:0]  POS_WIDTH    = 6'd18;
    localparam logic [5:0]  POS_HEIGHT   = 6'd22;
    localparam logic [5:0]  POS_DEPTH    = 6'd28;
    localparam logic [5:0]  POS_LAST_HDR = 6'(HEADER_BYTES - 1);

    // Supported pixel depths in bits.
    localparam logic [5:0] DEPTH_16 = 6'd16;
    localparam logic [5:0] DEPTH_24 = 6'd24;
    localparam logic [5:0] DEPTH_32 = 6'd32;

    // Alpha value for formats without an alpha channel.
    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    // One decoded pixel as held in the output register.
    typedef struct packed {
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] row;
        logic [CHAN_W-1:0]  red;
        logic [CHAN_W-1:0]  green;
        logic [CHAN_W-1:0]  blue;
        logic [CHAN_W-1:0]  alpha;
        logic               last;
    } pixel_t;

endpackage

`default_nettype wire

>>> hdl/bmp_pixel_stream_decoder.sv
// BMP pixel stream decoder: parses the 54-byte header and turns the pixel bytes
// into RGBA pixels with coordinates. Depends on bpsd_pkg.
`default_nettype none

// How the block is used:
// The input channel moves one byte of a BMP file per transfer (data_byte),
// with start_file marking the first byte of a new file. A start_file byte
// abandons any file in progress and is taken as header byte 0. The output
// channel moves one decoded pixel per transfer: its column, its row counted
// from the top of the image, the four channels and a flag on the final pixel.
// Header bytes, bytes up to the pixel data offset, row padding and all bytes
// after the last pixel produce nothing. Depths other than 16, 24 and 32 bits,
// and sizes of zero or above the maximum, produce no pixels at all.
// A byte is held in the input register and is decoded on its way into the
// output register, so a pixel is offered from the output register once its
// final byte has moved on from the input register.
// The block takes one byte per cycle while the receiver does not stall; a
// pixel therefore leaves at most once per 2, 3 or 4 bytes, the bytes per pixel.
// When the receiver stalls, the pending pixel holds in the output register and
// the input register holds the next byte, after which byte_ready drops.
// Reset empties both registers and leaves the decoder idle until a byte with
// start_file set arrives.
module bmp_pixel_stream_decoder (
    input  wire logic                         clk,
    input  wire logic                         rst_n,

    input  wire logic                         byte_valid,
    output logic                              byte_ready,
    input  wire logic [bpsd_pkg::BYTE_W-1:0]  data_byte,
    input  wire logic                         start_file,

    output logic                              pixel_valid,
    input  wire logic                         pixel_ready,
    output logic [bpsd_pkg::COORD_W-1:0]      pixel_column,
    output logic [bpsd_pkg::COORD_W-1:0]      pixel_row,
    output logic [bpsd_pkg::CHAN_W-1:0]       red,
    output logic [bpsd_pkg::CHAN_W-1:0]       green,
    output logic [bpsd_pkg::CHAN_W-1:0]       blue,
    output logic [bpsd_pkg::CHAN_W-1:0]       alpha,
    output logic                              last_pixel
);
    import bpsd_pkg::*;

    // Input register.
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_data_reg;
    logic              in_start_reg;

    // Output register.
    logic   out_valid_reg, out_valid_next;
    pixel_t out_pixel_reg, out_pixel_next;

    // Decoder state.
    logic [31:0]      byte_position_reg, byte_position_next;
    logic [DIM_W-1:0] image_width_reg,   image_width_next;
    logic [DIM_W-1:0] image_height_reg,  image_height_next;
    logic [5:0]       bit_depth_reg,     bit_depth_next;
    logic [31:0]      data_offset_reg,   data_offset_next;
    logic [CNT_W-1:0] column_count_reg,  column_count_next;
    logic [CNT_W-1:0] row_count_reg,     row_count_next;
    logic [1:0]       pixel_index_reg,   pixel_index_next;
    logic [23:0]      partial_pixel_reg, partial_pixel_next;
    logic [1:0]       padding_left_reg,  padding_left_next;
    logic             image_done_reg,    image_done_next;
    logic [31:0]      hdr_width_reg,     hdr_width_next;
    logic [31:0]      hdr_height_reg,    hdr_height_next;
    logic [15:0]      hdr_depth_reg,     hdr_depth_next;

    logic advance;
    logic emit;

    // The stored byte moves on when the output register can take a result.
    assign advance    = in_valid_reg && (!out_valid_reg || pixel_ready);
    assign byte_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (byte_ready)
        begin
            in_valid_reg <= byte_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_ready && byte_valid)
        begin
            in_data_reg  <= data_byte;
            in_start_reg <= start_file;
        end
    end

    // Decode of the byte in the input register.
    always_comb
    begin
        logic [5:0]       pos_lo;
        logic [1:0]       slot;
        logic [2:0]       nbytes;
        logic [15:0]      word16;
        logic             depth_ok;
        logic             size_ok;
        logic [DIM_W-1:0] col_plus;
        logic [DIM_W-1:0] row_plus;
        logic [DIM_W-1:0] row_flip;
        logic [31:0]      col_wide;
        logic [31:0]      row_wide;
        logic [1:0]       row_bytes_lo;
        logic [CHAN_W-1:0] r_v, g_v, b_v, a_v;

        // A start byte clears the file state before the byte is handled.
        if (in_start_reg)
        begin
            byte_position_next = '0;
            image_width_next   = '0;
            image_height_next  = '0;
            bit_depth_next     = '0;
            data_offset_next   = '0;
            column_count_next  = '0;
            row_count_next     = '0;
            pixel_index_next   = '0;
            partial_pixel_next = '0;
            padding_left_next  = '0;
            image_done_next    = 1'b0;
            hdr_width_next     = '0;
            hdr_height_next    = '0;
            hdr_depth_next     = '0;
        end
        else
        begin
            byte_position_next = byte_position_reg;
            image_width_next   = image_width_reg;
            image_height_next  = image_height_reg;
            bit_depth_next     = bit_depth_reg;
            data_offset_next   = data_offset_reg;
            column_count_next  = column_count_reg;
            row_count_next     = row_count_reg;
            pixel_index_next   = pixel_index_reg;
            partial_pixel_next = partial_pixel_reg;
            padding_left_next  = padding_left_reg;
            image_done_next    = image_done_reg;
            hdr_width_next     = hdr_width_reg;
            hdr_height_next    = hdr_height_reg;
            hdr_depth_next     = hdr_depth_reg;
        end

        pos_lo       = byte_position_next[5:0];
        slot         = 2'b00;
        nbytes       = bit_depth_next[5:3];
        word16       = {in_data_reg, partial_pixel_next[7:0]};
        depth_ok     = 1'b0;
        size_ok      = 1'b0;
        col_plus     = DIM_W'(column_count_next) + DIM_W'(1);
        row_plus     = DIM_W'(row_count_next) + DIM_W'(1);
        row_flip     = image_height_next - row_plus;
        col_wide     = 32'(column_count_next);
        row_wide     = 32'(row_flip);
        row_bytes_lo = 2'(image_width_next[1:0] * nbytes[1:0]);
        r_v          = '0;
        g_v          = '0;
        b_v          = '0;
        a_v          = ALPHA_OPAQUE;
        emit         = 1'b0;

        if (image_done_next)
        begin
            // Idle: the byte is dropped.
        end
        else if (byte_position_next < 32'(HEADER_BYTES))
        begin
            if (pos_lo >= POS_OFFSET && pos_lo <= POS_OFFSET + 6'd3)
            begin
                slot = 2'(pos_lo - POS_OFFSET);
                data_offset_next[8*slot +: 8] = in_data_reg;
            end
            if (pos_lo >= POS_WIDTH && pos_lo <= POS_WIDTH + 6'd3)
            begin
                slot = 2'(pos_lo - POS_WIDTH);
                hdr_width_next[8*slot +: 8] = in_data_reg;
            end
            if (pos_lo >= POS_HEIGHT && pos_lo <= POS_HEIGHT + 6'd3)
            begin
                slot = 2'(pos_lo - POS_HEIGHT);
                hdr_height_next[8*slot +: 8] = in_data_reg;
            end
            if (pos_lo >= POS_DEPTH && pos_lo <= POS_DEPTH + 6'd1)
            begin
                slot = 2'(pos_lo - POS_DEPTH);
                hdr_depth_next[8*slot[0] +: 8] = in_data_reg;
            end
            if (pos_lo == POS_LAST_HDR)
            begin
                depth_ok = hdr_depth_next == 16'(DEPTH_16) ||
                           hdr_depth_next == 16'(DEPTH_24) ||
                           hdr_depth_next == 16'(DEPTH_32);
                size_ok  = hdr_width_next != '0 &&
                           hdr_width_next <= 32'(MAX_DIMENSION) &&
                           hdr_height_next != '0 &&
                           hdr_height_next <= 32'(MAX_DIMENSION);
                if (depth_ok && size_ok)
                begin
                    image_width_next  = hdr_width_next[DIM_W-1:0];
                    image_height_next = hdr_height_next[DIM_W-1:0];
                    bit_depth_next    = hdr_depth_next[5:0];
                end
                else
                begin
                    image_done_next = 1'b1;
                end
            end
            byte_position_next = byte_position_next + 32'd1;
        end
        else if (byte_position_next < data_offset_next)
        begin
            byte_position_next = byte_position_next + 32'd1;
        end
        else if (padding_left_next != 2'd0)
        begin
            padding_left_next = padding_left_next - 2'd1;
        end
        else if (3'(pixel_index_next) + 3'd1 < nbytes)
        begin
            partial_pixel_next[8*pixel_index_next +: 8] = in_data_reg;
            pixel_index_next = pixel_index_next + 2'd1;
        end
        else
        begin
            emit = 1'b1;
            priority if (bit_depth_next == DEPTH_16)
            begin
                b_v = {word16[4:0], 3'b000};
                g_v = {word16[9:5], 3'b000};
                r_v = {word16[14:10], 3'b000};
            end
            else if (bit_depth_next == DEPTH_24)
            begin
                b_v = partial_pixel_next[7:0];
                g_v = partial_pixel_next[15:8];
                r_v = in_data_reg;
            end
            else
            begin
                b_v = partial_pixel_next[7:0];
                g_v = partial_pixel_next[15:8];
                r_v = partial_pixel_next[23:16];
                a_v = in_data_reg;
            end

            pixel_index_next   = '0;
            partial_pixel_next = '0;
            if (col_plus >= image_width_next)
            begin
                column_count_next = '0;
                if (row_plus >= image_height_next)
                begin
                    image_done_next = 1'b1;
                end
                else
                begin
                    row_count_next    = row_count_next + CNT_W'(1);
                    // Rows are padded to a multiple of four bytes.
                    padding_left_next = 2'd0 - row_bytes_lo;
                end
            end
            else
            begin
                column_count_next = column_count_next + CNT_W'(1);
            end
        end

        out_pixel_next.column = col_wide[COORD_W-1:0];
        out_pixel_next.row    = row_wide[COORD_W-1:0];
        out_pixel_next.red    = r_v;
        out_pixel_next.green  = g_v;
        out_pixel_next.blue   = b_v;
        out_pixel_next.alpha  = a_v;
        out_pixel_next.last   = emit && image_done_next;
    end

    always_comb
    begin
        if (advance)
        begin
            out_valid_next = emit;
        end
        else if (pixel_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg     <= 1'b0;
            byte_position_reg <= '0;
            image_width_reg   <= '0;
            image_height_reg  <= '0;
            bit_depth_reg     <= '0;
            data_offset_reg   <= '0;
            column_count_reg  <= '0;
            row_count_reg     <= '0;
            pixel_index_reg   <= '0;
            partial_pixel_reg <= '0;
            padding_left_reg  <= '0;
            image_done_reg    <= 1'b1;
            hdr_width_reg     <= '0;
            hdr_height_reg    <= '0;
            hdr_depth_reg     <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                byte_position_reg <= byte_position_next;
                image_width_reg   <= image_width_next;
                image_height_reg  <= image_height_next;
                bit_depth_reg     <= bit_depth_next;
                data_offset_reg   <= data_offset_next;
                column_count_reg  <= column_count_next;
                row_count_reg     <= row_count_next;
                pixel_index_reg   <= pixel_index_next;
                partial_pixel_reg <= partial_pixel_next;
                padding_left_reg  <= padding_left_next;
                image_done_reg    <= image_done_next;
                hdr_width_reg     <= hdr_width_next;
                hdr_height_reg    <= hdr_height_next;
                hdr_depth_reg     <= hdr_depth_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            out_pixel_reg <= out_pixel_next;
        end
    end

    assign pixel_valid  = out_valid_reg;
    assign pixel_column = out_pixel_reg.column;
    assign pixel_row    = out_pixel_reg.row;
    assign red          = out_pixel_reg.red;
    assign green        = out_pixel_reg.green;
    assign blue         = out_pixel_reg.blue;
    assign alpha        = out_pixel_reg.alpha;
    assign last_pixel   = out_pixel_reg.last;

endmodule

`default_nettype wire
